### sv/crcfr_pkg.sv
// Shared types, operation codes and the CRC-16/CCITT byte update for the frame receiver.
// Used by every module of the receiver; depends on nothing else.
package crcfr_pkg;

   // Operations that the front end hands to the back end.
   localparam logic [3:0] OP_START  = 4'd0;
   localparam logic [3:0] OP_CMD    = 4'd1;
   localparam logic [3:0] OP_LEN    = 4'd2;
   localparam logic [3:0] OP_BADLEN = 4'd3;
   localparam logic [3:0] OP_DATA   = 4'd4;
   localparam logic [3:0] OP_CRCL   = 4'd5;
   localparam logic [3:0] OP_CRCH   = 4'd6;
   localparam logic [3:0] OP_ENDOK  = 4'd7;
   localparam logic [3:0] OP_NOEND  = 4'd8;

   // Event codes reported on the result channel.
   localparam logic [2:0] EV_DATA   = 3'd0;
   localparam logic [2:0] EV_GOOD   = 3'd1;
   localparam logic [2:0] EV_CRC    = 3'd2;
   localparam logic [2:0] EV_NOEND  = 3'd3;
   localparam logic [2:0] EV_BADLEN = 3'd4;

   // CRC constants.
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_START_MARKER = 2'd0;
   localparam logic [1:0] REG_END_MARKER   = 2'd1;
   localparam logic [1:0] REG_MAX_LENGTH   = 2'd2;

   // Queue depth between front end and back end.
   localparam int QUEUE_DEPTH = 2;

   // One classified byte.
   typedef struct packed {
      logic [3:0] op;
      logic [7:0] data;
      logic [7:0] index;
   } crcfr_op_type;

   // MSB-first CRC update over one byte, unrolled over its eight bits.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### sv/crc16_frame_receiver_core.sv
// Top level of the CRC-16 frame receiver: configuration registers and the wiring of
// front end, operation queue and back end. Depends on crcfr_pkg and the crcfr_* modules.
//
//   Channel   Direction  Handshake                 Contents
//   req_      in         tvalid/tready             tdata: rx_byte
//   rsp_      out        tvalid/tready             tuser: event_res; tdata: frame fields
//   csr_      in/out     APB setup + access        start, end marker, max payload length
//
// One byte is taken per cycle while the queue has room. Its operation is written to the
// queue as the byte is taken, and the back end executes it from the queue head into the
// result register once that register is free. The rate is set by the unrolled CRC byte
// update in the back end. Synchronous reset clears the phase, queue and counters and sets
// the CRC to CRC_INIT. A stall on the result side fills the two-entry queue, after which
// req_tready drops; it rises again in the cycle after the waiting result is taken.
module crc16_frame_receiver_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [2:0] event_res
   output logic [95:0] rsp_tdata,   // [7:0] command, [15:8] length, [23:16] data_byte,
                                    // [31:24] data_index, [47:32] computed_crc,
                                    // [63:48] good_frames, [79:64] crc_errors,
                                    // [95:80] framing_errors
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import crcfr_pkg::*;

   logic [7:0]   start_marker_ff;
   logic [7:0]   end_marker_ff;
   logic [7:0]   max_length_ff;
   logic         csr_write;
   logic [1:0]   csr_index;
   logic         q_full;
   logic         q_not_empty;
   logic         q_push;
   logic         q_pop;
   crcfr_op_type push_op;
   crcfr_op_type head_op;

   // Register file write and read.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= 8'hAA;
         end_marker_ff   <= 8'h55;
         max_length_ff   <= 8'd64;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_START_MARKER: start_marker_ff <= csr_pwdata[7:0];
            REG_END_MARKER:   end_marker_ff   <= csr_pwdata[7:0];
            REG_MAX_LENGTH:   max_length_ff   <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_START_MARKER: csr_prdata = {24'd0, start_marker_ff};
         REG_END_MARKER:   csr_prdata = {24'd0, end_marker_ff};
         REG_MAX_LENGTH:   csr_prdata = {24'd0, max_length_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // Byte classification.
   crcfr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .rx_byte      (req_tdata),
      .byte_valid   (req_tvalid),
      .queue_full   (q_full),
      .start_marker (start_marker_ff),
      .end_marker   (end_marker_ff),
      .max_length   (max_length_ff),
      .byte_ready   (req_tready),
      .push         (q_push),
      .push_op      (push_op)
   );

   // Decoupling queue.
   crcfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_op   (push_op),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_op   (head_op)
   );

   // Execution and result register.
   crcfr_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (q_not_empty),
      .op_in       (head_op),
      .op_pop      (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_event   (rsp_tuser),
      .rsp_payload (rsp_tdata)
   );

endmodule

### sv/crcfr_front.sv
// Front end of the frame receiver: tracks the frame phase and classifies each byte.
// Depends on crcfr_pkg for operation codes and the operation type.
module crcfr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            rx_byte,
   input  logic                  byte_valid,
   input  logic                  queue_full,
   input  logic [7:0]            start_marker,
   input  logic [7:0]            end_marker,
   input  logic [7:0]            max_length,
   output logic                  byte_ready,
   output logic                  push,
   output crcfr_pkg::crcfr_op_type push_op
);
   import crcfr_pkg::*;

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_CMD     = 3'd1;
   localparam logic [2:0] PH_LEN     = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CRCL    = 3'd4;
   localparam logic [2:0] PH_CRCH    = 3'd5;
   localparam logic [2:0] PH_END     = 3'd6;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] count_ff, count_in;
   logic       take;
   logic       emit;
   logic [8:0] count_next;

   // A byte is taken whenever the queue has room for its operation.
   assign byte_ready = !queue_full;
   assign take       = byte_valid && !queue_full;
   assign push       = take && emit;
   assign count_next = {1'b0, count_ff} + 9'd1;

   // Phase update and classification of the byte at the input.
   always_comb begin
      phase_in      = phase_ff;
      length_in     = length_ff;
      count_in      = count_ff;
      emit          = 1'b0;
      push_op.op    = OP_START;
      push_op.data  = rx_byte;
      push_op.index = 8'd0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == start_marker) begin
               emit     = 1'b1;
               phase_in = PH_CMD;
            end
         end
         PH_CMD: begin
            emit       = 1'b1;
            push_op.op = OP_CMD;
            phase_in   = PH_LEN;
         end
         PH_LEN: begin
            emit      = 1'b1;
            length_in = rx_byte;
            count_in  = 8'd0;
            if (rx_byte == 8'd0) begin
               push_op.op = OP_LEN;
               phase_in   = PH_CRCL;
            end else if (rx_byte <= max_length) begin
               push_op.op = OP_LEN;
               phase_in   = PH_PAYLOAD;
            end else begin
               push_op.op = OP_BADLEN;
               phase_in   = PH_HUNT;
            end
         end
         PH_PAYLOAD: begin
            emit          = 1'b1;
            push_op.op    = OP_DATA;
            push_op.index = count_ff;
            count_in      = count_next[7:0];
            if (count_next >= {1'b0, length_ff}) begin
               phase_in = PH_CRCL;
            end
         end
         PH_CRCL: begin
            emit       = 1'b1;
            push_op.op = OP_CRCL;
            phase_in   = PH_CRCH;
         end
         PH_CRCH: begin
            emit       = 1'b1;
            push_op.op = OP_CRCH;
            phase_in   = PH_END;
         end
         PH_END: begin
            emit       = 1'b1;
            push_op.op = (rx_byte == end_marker) ? OP_ENDOK : OP_NOEND;
            phase_in   = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // Phase registers advance only on a taken byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         length_ff <= 8'd0;
         count_ff  <= 8'd0;
      end else if (take) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/crcfr_queue.sv
// Two-entry queue of classified operations between front end and back end.
// Depends on crcfr_pkg for the operation type and the queue depth.
module crcfr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  crcfr_pkg::crcfr_op_type push_op,
   input  logic                   pop,
   output logic                   full,
   output logic                   not_empty,
   output crcfr_pkg::crcfr_op_type head_op
);
   import crcfr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   crcfr_op_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_op   = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   // Pointer and fill count updates; wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; entries are read only after being written.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### sv/crcfr_back.sv
// Back end of the frame receiver: CRC, stored CRC, counters and the result register.
// Depends on crcfr_pkg for operation and event codes and the CRC update function.
module crcfr_back #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_valid,
   input  crcfr_pkg::crcfr_op_type op_in,
   output logic                   op_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_event,
   output logic [95:0]            rsp_payload
);
   import crcfr_pkg::*;

   logic [7:0]             command_ff, command_in;
   logic [7:0]             length_ff, length_in;
   logic [15:0]            crc_ff, crc_in;
   logic [15:0]            rcrc_ff, rcrc_in;
   logic [COUNT_WIDTH-1:0] good_ff, good_in;
   logic [COUNT_WIDTH-1:0] crcerr_ff, crcerr_in;
   logic [COUNT_WIDTH-1:0] framing_ff, framing_in;
   logic                   out_valid_ff, out_valid_in;
   logic [2:0]             out_event_ff, out_event_in;
   logic [7:0]             out_data_ff, out_data_in;
   logic [7:0]             out_index_ff, out_index_in;
   logic [15:0]            crc_upd;
   logic                   emit;
   logic [15:0]            good_ext, crcerr_ext, framing_ext;
   logic [15:0]            out_good_ff, out_crcerr_ff, out_framing_ff;
   logic [7:0]             out_command_ff, out_length_ff;
   logic [15:0]            out_crc_ff;

   // An operation is executed when the result register is free or being drained.
   assign op_pop  = op_valid && (!out_valid_ff || rsp_ready);
   assign crc_upd = crc_byte(crc_ff, op_in.data);

   // Execute one operation.
   always_comb begin
      command_in   = command_ff;
      length_in    = length_ff;
      crc_in       = crc_ff;
      rcrc_in      = rcrc_ff;
      good_in      = good_ff;
      crcerr_in    = crcerr_ff;
      framing_in   = framing_ff;
      emit         = 1'b0;
      out_event_in = EV_DATA;
      out_data_in  = 8'd0;
      out_index_in = 8'd0;
      unique case (op_in.op)
         OP_START: begin
            crc_in = CRC_INIT;
         end
         OP_CMD: begin
            command_in = op_in.data;
            crc_in     = crc_upd;
         end
         OP_LEN: begin
            length_in = op_in.data;
            crc_in    = crc_upd;
         end
         OP_BADLEN: begin
            length_in    = op_in.data;
            crc_in       = crc_upd;
            framing_in   = framing_ff + 1'b1;
            emit         = 1'b1;
            out_event_in = EV_BADLEN;
         end
         OP_DATA: begin
            crc_in       = crc_upd;
            emit         = 1'b1;
            out_event_in = EV_DATA;
            out_data_in  = op_in.data;
            out_index_in = op_in.index;
         end
         OP_CRCL: begin
            rcrc_in = {8'h00, op_in.data};
         end
         OP_CRCH: begin
            rcrc_in = {op_in.data, rcrc_ff[7:0]};
         end
         OP_ENDOK: begin
            emit = 1'b1;
            if (crc_ff == rcrc_ff) begin
               good_in      = good_ff + 1'b1;
               out_event_in = EV_GOOD;
            end else begin
               crcerr_in    = crcerr_ff + 1'b1;
               out_event_in = EV_CRC;
            end
         end
         OP_NOEND: begin
            framing_in   = framing_ff + 1'b1;
            emit         = 1'b1;
            out_event_in = EV_NOEND;
         end
         default: begin
         end
      endcase
   end

   // Reported counts: low 16 bits of updated counters, zero-extended if narrower.
   generate
      if (COUNT_WIDTH >= 16) begin : g_cnt_trunc
         assign good_ext    = good_in[15:0];
         assign crcerr_ext  = crcerr_in[15:0];
         assign framing_ext = framing_in[15:0];
      end else begin : g_cnt_ext
         assign good_ext    = {{(16-COUNT_WIDTH){1'b0}}, good_in};
         assign crcerr_ext  = {{(16-COUNT_WIDTH){1'b0}}, crcerr_in};
         assign framing_ext = {{(16-COUNT_WIDTH){1'b0}}, framing_in};
      end
   endgenerate

   // The result register holds until taken; a new result may load as it leaves.
   always_comb begin
      if (op_pop && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Frame state and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff   <= 8'd0;
         length_ff    <= 8'd0;
         crc_ff       <= CRC_INIT;
         rcrc_ff      <= 16'd0;
         good_ff      <= '0;
         crcerr_ff    <= '0;
         framing_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (op_pop) begin
            command_ff <= command_in;
            length_ff  <= length_in;
            crc_ff     <= crc_in;
            rcrc_ff    <= rcrc_in;
            good_ff    <= good_in;
            crcerr_ff  <= crcerr_in;
            framing_ff <= framing_in;
         end
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (op_pop && emit) begin
         out_event_ff   <= out_event_in;
         out_command_ff <= command_in;
         out_length_ff  <= length_in;
         out_data_ff    <= out_data_in;
         out_index_ff   <= out_index_in;
         out_crc_ff     <= crc_in;
         out_good_ff    <= good_ext;
         out_crcerr_ff  <= crcerr_ext;
         out_framing_ff <= framing_ext;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_event   = out_event_ff;
   assign rsp_payload = {out_framing_ff, out_crcerr_ff, out_good_ff, out_crc_ff,
                         out_index_ff, out_data_ff, out_length_ff, out_command_ff};

endmodule

### sim/crc16_frame_receiver_checker.sv
// Checker for the CRC-16 frame receiver: a parser that predicts results from the observed
// input and configuration transactions, and a scoreboard for the result channel.
// Depends on crcfr_pkg for event codes and register indexes; holds the shared CRC helper package.
package crcfr_check_pkg;

   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [15:0] CRC_GEN  = 16'h1021;

   // CRC-16/CCITT, MSB first, one message bit at a time.
   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      logic        feedback;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = acc[15] ^ b[i];
         acc = {acc[14:0], 1'b0};
         if (feedback) begin
            acc = acc ^ CRC_GEN;
         end
      end
      return acc;
   endfunction

endpackage

module crc16_frame_receiver_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [2:0]  rsp_tuser,   // [2:0] event_res
   input  logic [95:0] rsp_tdata,   // [7:0] command, [15:8] length, [23:16] data_byte,
                                    // [31:24] data_index, [47:32] computed_crc,
                                    // [63:48] good_frames, [79:64] crc_errors,
                                    // [95:80] framing_errors
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failures,
   output int          pending,
   output int          results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import crcfr_pkg::*;
   import crcfr_check_pkg::*;

   typedef enum logic [2:0] {
      ST_HUNT, ST_CMD, ST_LEN, ST_PAYLOAD, ST_CRC_LO, ST_CRC_HI, ST_END
   } parse_state_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  command;
      logic [7:0]  length;
      logic [7:0]  data_byte;
      logic [7:0]  data_index;
      logic [15:0] crc;
      logic [15:0] good;
      logic [15:0] crc_errs;
      logic [15:0] framing;
   } rx_result_type;

   // Register copies, updated from observed write transactions.
   logic [7:0]   cfg_start;
   logic [7:0]   cfg_end;
   logic [7:0]   cfg_max;

   // Parser state.
   parse_state_type parse_state;
   logic [7:0]   frame_cmd;
   logic [7:0]   frame_len;
   logic [7:0]   payload_pos;
   logic [15:0]  crc_acc;
   logic [15:0]  crc_rx;
   logic [15:0]  good_cnt;
   logic [15:0]  crc_err_cnt;
   logic [15:0]  framing_cnt;

   rx_result_type expected_results[$];
   int           fail_count;
   int           checked_count;

   // Advance the parser by one received byte and queue the result it causes, if any.
   task automatic parse_rx_byte(input logic [7:0] b);
      rx_result_type res;
      logic       produces;
      produces = 1'b0;
      res = '0;
      case (parse_state)
         ST_HUNT: begin
            if (b == cfg_start) begin
               crc_acc = CRC_SEED;
               parse_state = ST_CMD;
            end
         end
         ST_CMD: begin
            frame_cmd = b;
            crc_acc = crc16_update(crc_acc, b);
            parse_state = ST_LEN;
         end
         ST_LEN: begin
            frame_len = b;
            payload_pos = 8'd0;
            crc_acc = crc16_update(crc_acc, b);
            if (b == 8'd0) begin
               parse_state = ST_CRC_LO;
            end else if (b <= cfg_max) begin
               parse_state = ST_PAYLOAD;
            end else begin
               // An oversized length is reported after the CRC has taken it in.
               framing_cnt = framing_cnt + 16'd1;
               parse_state = ST_HUNT;
               produces = 1'b1;
               res.kind = EV_BADLEN;
            end
         end
         ST_PAYLOAD: begin
            res.data_index = payload_pos;
            res.data_byte = b;
            res.kind = EV_DATA;
            produces = 1'b1;
            crc_acc = crc16_update(crc_acc, b);
            payload_pos = payload_pos + 8'd1;
            if (payload_pos >= frame_len) begin
               parse_state = ST_CRC_LO;
            end
         end
         ST_CRC_LO: begin
            crc_rx = {8'h00, b};
            parse_state = ST_CRC_HI;
         end
         ST_CRC_HI: begin
            crc_rx[15:8] = b;
            parse_state = ST_END;
         end
         ST_END: begin
            // The stored CRC only matters when the end marker is in place.
            parse_state = ST_HUNT;
            produces = 1'b1;
            if (b != cfg_end) begin
               framing_cnt = framing_cnt + 16'd1;
               res.kind = EV_NOEND;
            end else if (crc_acc == crc_rx) begin
               good_cnt = good_cnt + 16'd1;
               res.kind = EV_GOOD;
            end else begin
               crc_err_cnt = crc_err_cnt + 16'd1;
               res.kind = EV_CRC;
            end
         end
         default: begin
            parse_state = ST_HUNT;
         end
      endcase
      if (produces) begin
         res.command = frame_cmd;
         res.length = frame_len;
         res.crc = crc_acc;
         res.good = good_cnt;
         res.crc_errs = crc_err_cnt;
         res.framing = framing_cnt;
         expected_results.push_back(res);
      end
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Compare one result transaction with the oldest expected result.
   task automatic check_result();
      rx_result_type want;
      if (expected_results.size() == 0) begin
         $error("result transaction with none expected: event_res %0d, data 0x%0h",
                rsp_tuser, rsp_tdata);
         fail_count++;
      end else begin
         want = expected_results.pop_front();
         check_field("event_res", 16'(want.kind), 16'(rsp_tuser));
         check_field("command", 16'(want.command), 16'(rsp_tdata[7:0]));
         check_field("length", 16'(want.length), 16'(rsp_tdata[15:8]));
         check_field("data_byte", 16'(want.data_byte), 16'(rsp_tdata[23:16]));
         check_field("data_index", 16'(want.data_index), 16'(rsp_tdata[31:24]));
         check_field("computed_crc", want.crc, rsp_tdata[47:32]);
         check_field("good_frames", want.good, rsp_tdata[63:48]);
         check_field("crc_errors", want.crc_errs, rsp_tdata[79:64]);
         check_field("framing_errors", want.framing, rsp_tdata[95:80]);
         checked_count++;
      end
   endtask

   // Sample all channels at the clock edge; a byte taken at the same edge as a register
   // write still sees the old register value.
   always @(posedge clock) begin
      if (reset) begin
         cfg_start = 8'hAA;
         cfg_end = 8'h55;
         cfg_max = 8'd64;
         parse_state = ST_HUNT;
         frame_cmd = 8'd0;
         frame_len = 8'd0;
         payload_pos = 8'd0;
         crc_acc = CRC_SEED;
         crc_rx = 16'd0;
         good_cnt = 16'd0;
         crc_err_cnt = 16'd0;
         framing_cnt = 16'd0;
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            parse_rx_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_START_MARKER: cfg_start = csr_pwdata[7:0];
               REG_END_MARKER:   cfg_end = csr_pwdata[7:0];
               REG_MAX_LENGTH:   cfg_max = csr_pwdata[7:0];
               default: ;
            endcase
         end
      end
      failures <= fail_count;
      pending <= expected_results.size();
      results_checked <= checked_count;
   end

endmodule

### sim/crc16_frame_receiver_core_test.sv
// Top of the frame receiver testbench: clock, reset, byte and register stimulus, receiver
// back-pressure and the verdict. Depends on crcfr_pkg, crcfr_check_pkg and the checker.
module crc16_frame_receiver_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import crcfr_pkg::*;
   import crcfr_check_pkg::*;

   localparam int         PHASE_BYTES  = 275;
   localparam int         DRAIN_CYCLES = 6;
   localparam int         HOLD_CYCLES  = 200;
   localparam int         LIMIT_CYCLES = 400000;
   localparam logic [1:0] REG_UNUSED   = 2'd3;

   typedef enum {FRAME_GOOD, FRAME_BAD_CRC, FRAME_NO_END, FRAME_BAD_LEN} frame_kind_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;     // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;            // [2:0] event_res
   logic [95:0] rsp_tdata;            // [7:0] command, [15:8] length, [23:16] data_byte,
                                      // [31:24] data_index, [47:32] computed_crc,
                                      // [63:48] good_frames, [79:64] crc_errors,
                                      // [95:80] framing_errors
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          failures;
   int          pending;
   int          results_checked;

   // Register values as last written, used to build frames.
   logic [7:0]  cur_start = 8'hAA;
   logic [7:0]  cur_end = 8'h55;
   logic [7:0]  cur_max = 8'd64;

   int          idle_pct = 0;
   int          stall_pct = 0;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          cycle_count = 0;
   int          bytes_sent = 0;
   int          frames_sent = 0;
   int          noise_bursts = 0;

   crc16_frame_receiver_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   crc16_frame_receiver_checker frame_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tuser       (rsp_tuser),
      .rsp_tdata       (rsp_tdata),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .failures        (failures),
      .pending         (pending),
      .results_checked (results_checked)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                  pending);
         $display("[crc16_frame_receiver_core] ERROR");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one byte after a random gap and wait for its transaction.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Send one frame; the kind decides which part of it is broken.
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                             input frame_kind_type kind, input bit extremes);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = crc16_update(CRC_SEED, cmd);
      crc = crc16_update(crc, len);
      frames_sent++;
      send_byte(cur_start);
      send_byte(cmd);
      send_byte(len);
      if (kind != FRAME_BAD_LEN) begin
         for (int i = 0; i < len; i++) begin
            b = extremes ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom);
            crc = crc16_update(crc, b);
            send_byte(b);
         end
         if (kind == FRAME_BAD_CRC) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
         end
         send_byte(crc[7:0]);
         send_byte(crc[15:8]);
         if (kind == FRAME_NO_END) begin
            send_byte(cur_end ^ 8'($urandom_range(255, 1)));
         end else begin
            send_byte(cur_end);
         end
      end
   endtask

   // Mostly short payloads, now and then the full allowed length.
   function automatic logic [7:0] pick_length();
      int roll;
      roll = $urandom_range(99);
      if (cur_max == 8'd0 || roll < 15) begin
         return 8'd0;
      end
      if (roll < 85) begin
         return 8'($urandom_range((cur_max < 8'd8) ? int'(cur_max) : 8, 1));
      end
      if (roll < 97) begin
         return 8'($urandom_range((cur_max < 8'd32) ? int'(cur_max) : 32, 0));
      end
      return cur_max;
   endfunction

   // Random traffic: mostly frames with random content, some broken, some line noise.
   task automatic run_traffic(input int n_bytes);
      int target;
      int roll;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         roll = $urandom_range(99);
         if (roll < 12) begin
            noise_bursts++;
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
         end else if (roll < 60) begin
            send_frame(8'($urandom), pick_length(), FRAME_GOOD, 1'b0);
         end else if (roll < 74) begin
            send_frame(8'($urandom), pick_length(), FRAME_BAD_CRC, 1'b0);
         end else if (roll < 88) begin
            send_frame(8'($urandom), pick_length(), FRAME_NO_END, 1'b0);
         end else if (cur_max < 8'd255) begin
            send_frame(8'($urandom), 8'($urandom_range(255, int'(cur_max) + 1)),
                       FRAME_BAD_LEN, 1'b0);
         end else begin
            send_frame(8'($urandom), pick_length(), FRAME_GOOD, 1'b0);
         end
      end
   endtask

   // Stop offering bytes and let every expected result and any silent byte drain out.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One write transaction: setup cycle, then access cycle until pready.
   task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
      logic [31:0] word;
      word = $urandom;
      word[7:0] = value;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_START_MARKER: cur_start = value;
         REG_END_MARKER:   cur_end = value;
         REG_MAX_LENGTH:   cur_max = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [7:0] start_val, input logic [7:0] end_val,
                                input logic [7:0] max_val);
      write_reg(REG_START_MARKER, start_val);
      write_reg(REG_END_MARKER, end_val);
      write_reg(REG_MAX_LENGTH, max_val);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values, no idling: each outcome once, then random traffic.
      send_byte(8'h00);
      send_byte(8'h7F);
      send_frame(8'hFF, 8'd0, FRAME_GOOD, 1'b0);
      send_frame(8'h00, 8'd2, FRAME_BAD_CRC, 1'b1);
      send_frame(8'h5A, 8'hFF, FRAME_BAD_LEN, 1'b0);
      send_frame(8'h3C, 8'd0, FRAME_NO_END, 1'b0);
      run_traffic(PHASE_BYTES);

      // Lowest start marker, highest end marker and length limit; sparse sender.
      drain_results();
      apply_setting(8'h00, 8'hFF, 8'd255);
      idle_pct = 87;
      stall_pct = 0;
      run_traffic(PHASE_BYTES);

      // Opposite marker extremes, one-byte payload limit; slow receiver.
      drain_results();
      apply_setting(8'hFF, 8'h00, 8'd1);
      idle_pct = 0;
      stall_pct = 87;
      run_traffic(PHASE_BYTES);

      // A zero limit turns every nonzero length into a bad length.
      drain_results();
      apply_setting(8'($urandom), 8'($urandom), 8'd0);
      idle_pct = 9;
      stall_pct = 9;
      run_traffic(PHASE_BYTES);

      // Random setting, plus a write to an unmapped register that must change nothing.
      drain_results();
      apply_setting(8'($urandom), 8'($urandom), 8'($urandom_range(255, 1)));
      write_reg(REG_UNUSED, 8'($urandom));
      idle_pct = 0;
      stall_pct = 0;
      run_traffic(PHASE_BYTES);

      // Long receiver hold-off while a long frame keeps arriving back to back.
      drain_results();
      apply_setting(8'hAA, 8'h55, 8'd255);
      hold_requests <= hold_requests + 1;
      send_frame(8'hC3, 8'd40, FRAME_GOOD, 1'b0);
      run_traffic(PHASE_BYTES);

      drain_results();
      $display("Sent %0d bytes in %0d frames and %0d noise bursts over six register settings;",
               bytes_sent, frames_sent, noise_bursts);
      $display("%0d result transactions checked, one long receiver hold-off included.",
               results_checked);
      if (failures == 0) begin
         $display("[crc16_frame_receiver_core] OK");
      end else begin
         $display("[crc16_frame_receiver_core] ERROR");
      end
      $finish;
   end

endmodule
